// ===== rtl/u8vc_pkg.sv =====
// Shared types, constants and code point classification for the UTF-8 visible character counter.
package u8vc_pkg;

    localparam int unsigned COUNT_WIDTH_DEFAULT = 32;
    localparam int unsigned RESULT_WIDTH        = 32;
    localparam int unsigned BYTE_WIDTH          = 8;
    localparam int unsigned CP_WIDTH            = 21;

    // Code point limits
    localparam logic [CP_WIDTH-1:0] CP_MAX         = 21'h10FFFF;
    localparam logic [CP_WIDTH-1:0] SURROGATE_LO   = 21'h00D800;
    localparam logic [CP_WIDTH-1:0] SURROGATE_HI   = 21'h00DFFF;
    localparam logic [CP_WIDTH-1:0] REGIONAL_LO    = 21'h01F1E6;
    localparam logic [CP_WIDTH-1:0] REGIONAL_HI    = 21'h01F1FF;
    localparam logic [CP_WIDTH-1:0] MIN_CP_TWO     = 21'h000080;
    localparam logic [CP_WIDTH-1:0] MIN_CP_THREE   = 21'h000800;
    localparam logic [CP_WIDTH-1:0] MIN_CP_FOUR    = 21'h010000;

    // Sequence length classes
    localparam logic [1:0] SEQ_NONE  = 2'd0;
    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    // Decoder state carried between bytes
    typedef struct packed {
        logic [1:0]          expected;
        logic [CP_WIDTH-1:0] partial;
        logic [1:0]          len_class;
    } u8vc_dec_state_t;

    // Completed code point from one byte
    typedef struct packed {
        logic                take;
        logic [CP_WIDTH-1:0] cp;
    } u8vc_cp_t;

    // Combining marks, variation selectors, ZWJ and ZWNJ
    function automatic logic is_non_spacing(input logic [CP_WIDTH-1:0] cp);
        return cp inside {[21'h000300 : 21'h00036F], [21'h001AB0 : 21'h001AFF],
                          [21'h001DC0 : 21'h001DFF], [21'h0020D0 : 21'h0020FF],
                          [21'h00FE20 : 21'h00FE2F], [21'h00FE00 : 21'h00FE0F],
                          [21'h0E0100 : 21'h0E01EF], 21'h00200D, 21'h00200C};
    endfunction

    function automatic logic is_regional(input logic [CP_WIDTH-1:0] cp);
        return (cp >= REGIONAL_LO) && (cp <= REGIONAL_HI);
    endfunction

endpackage

// ===== rtl/u8vc_decode.sv =====
// One-byte UTF-8 decode step: next decoder state and any completed, well-formed code point.
module u8vc_decode
(
    input  logic [7:0]                 text_byte,
    input  u8vc_pkg::u8vc_dec_state_t  state,
    output u8vc_pkg::u8vc_dec_state_t  state_next,
    output u8vc_pkg::u8vc_cp_t         cp_out
);
    import u8vc_pkg::*;

    logic                is_cont;
    logic [CP_WIDTH-1:0] shifted;
    logic [1:0]          exp_dec;
    logic [CP_WIDTH-1:0] min_cp;
    logic                cp_ok;

    // Gather continuation bits and check the finished value
    always_comb
    begin
        is_cont = (text_byte[7:6] == 2'b10);
        shifted = {state.partial[CP_WIDTH-7:0], text_byte[5:0]};
        exp_dec = state.expected - 2'd1;
        case (state.len_class)
            SEQ_TWO:   min_cp = MIN_CP_TWO;
            SEQ_THREE: min_cp = MIN_CP_THREE;
            default:   min_cp = MIN_CP_FOUR;
        endcase
        cp_ok = (shifted >= min_cp) && (shifted <= CP_MAX)
                && !((shifted >= SURROGATE_LO) && (shifted <= SURROGATE_HI));
    end

    // Advance the sequence, or restart on a lead byte
    always_comb
    begin
        state_next  = state;
        cp_out.take = 1'b0;
        cp_out.cp   = shifted;
        if ((state.expected != 2'd0) && is_cont)
        begin
            if (exp_dec == 2'd0)
            begin
                state_next  = '0;
                cp_out.take = cp_ok;
            end
            else
            begin
                state_next.expected = exp_dec;
                state_next.partial  = shifted;
            end
        end
        else
        begin
            // drop any broken sequence and decode this byte as a lead
            state_next = '0;
            if (text_byte[7] == 1'b0)
            begin
                cp_out.take = 1'b1;
                cp_out.cp   = {{(CP_WIDTH-8){1'b0}}, text_byte};
            end
            else if (text_byte[7:5] == 3'b110)
            begin
                state_next.expected  = 2'd1;
                state_next.len_class = SEQ_TWO;
                state_next.partial   = {{(CP_WIDTH-5){1'b0}}, text_byte[4:0]};
            end
            else if (text_byte[7:4] == 4'b1110)
            begin
                state_next.expected  = 2'd2;
                state_next.len_class = SEQ_THREE;
                state_next.partial   = {{(CP_WIDTH-4){1'b0}}, text_byte[3:0]};
            end
            else if (text_byte[7:3] == 5'b11110)
            begin
                state_next.expected  = 2'd3;
                state_next.len_class = SEQ_FOUR;
                state_next.partial   = {{(CP_WIDTH-3){1'b0}}, text_byte[2:0]};
            end
        end
    end

endmodule

// ===== rtl/utf8_visible_char_counter_core.sv =====
// Top level: UTF-8 visible character counter on a byte stream.
// Path: the request with tlast is taken into the input register, then the decode step loads
// the result register that drives the count on the master side. Throughput: one byte per
// cycle but for the stall below; the decode step and count update are a single register stage.
// A finished count waiting on the master side stalls the input only when a further tlast arrives.
// Reset: rst_n clears all valid flags, decoder state, pairing flag and the running count.
module utf8_visible_char_counter_core
#(
    parameter int unsigned COUNT_WIDTH = u8vc_pkg::COUNT_WIDTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_buffer
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] visible_count
);
    import u8vc_pkg::*;

    logic                   in_valid_reg;
    logic [BYTE_WIDTH-1:0]  in_byte_reg;
    logic                   in_last_reg;
    u8vc_dec_state_t        dec_state_reg;
    u8vc_dec_state_t        dec_state_next;
    u8vc_cp_t               cp_event;
    logic                   flag_reg;
    logic                   flag_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [RESULT_WIDTH-1:0] count_clamped;
    logic                   out_valid_reg;
    logic [RESULT_WIDTH-1:0] out_data_reg;
    logic                   step_fire;
    logic                   bump;

    // Process the held request unless it would overwrite an untaken result
    assign step_fire     = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step_fire;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    u8vc_decode u_decode
    (
        .text_byte  (in_byte_reg),
        .state      (dec_state_reg),
        .state_next (dec_state_next),
        .cp_out     (cp_event)
    );

    // Classify the code point and update pairing flag and count
    always_comb
    begin
        flag_next = flag_reg;
        bump      = 1'b0;
        if (cp_event.take && !is_non_spacing(cp_event.cp))
        begin
            if (is_regional(cp_event.cp))
            begin
                flag_next = !flag_reg;
                bump      = !flag_reg;
            end
            else
            begin
                flag_next = 1'b0;
                bump      = 1'b1;
            end
        end
        count_next = (bump && (count_reg != '1)) ? count_reg + COUNT_WIDTH'(1) : count_reg;
    end

    // Clamp the count to the result field
    generate
        if (COUNT_WIDTH > RESULT_WIDTH)
        begin : g_clamp_wide
            assign count_clamped = (|count_next[COUNT_WIDTH-1:RESULT_WIDTH]) ? '1
                                   : count_next[RESULT_WIDTH-1:0];
        end
        else if (COUNT_WIDTH == RESULT_WIDTH)
        begin : g_clamp_equal
            assign count_clamped = count_next;
        end
        else
        begin : g_clamp_narrow
            assign count_clamped = {{(RESULT_WIDTH-COUNT_WIDTH){1'b0}}, count_next};
        end
    endgenerate

    // Hold the input request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_last_reg  <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
            in_last_reg  <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Advance decoder state and count; clear after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_state_reg <= '0;
            flag_reg      <= 1'b0;
            count_reg     <= '0;
        end
        else if (step_fire)
        begin
            if (in_last_reg)
            begin
                dec_state_reg <= '0;
                flag_reg      <= 1'b0;
                count_reg     <= '0;
            end
            else
            begin
                dec_state_reg <= dec_state_next;
                flag_reg      <= flag_next;
                count_reg     <= count_next;
            end
        end
    end

    // Load the result register on the last byte, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_fire && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire && in_last_reg)
        begin
            out_data_reg <= count_clamped;
        end
    end

endmodule

// ===== rtl/u8vc_checker.sv =====
// Port-level checker for the UTF-8 visible character counter, bound to the top level.
module u8vc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       last_in;
    logic       result_out;

    assign last_in    = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign result_out = m_axis_tvalid && m_axis_tready;

    // Track buffers taken in but not yet answered
    always_comb
    begin
        pending_next = pending_reg;
        if (last_in && !result_out)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!last_in && result_out)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result holds its count
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // Every result answers a buffer whose last byte was taken
    a_result_owed: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 2'd0)
        else $error("result without a completed buffer");

    // At most one buffer in the input stage and one in the result register
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("too many buffers awaiting a result");

    // Input back-pressure only comes from a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a stalled result");

endmodule

bind utf8_visible_char_counter_core u8vc_checker u_u8vc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/u8vc_count_checker.sv =====
// Checker for the UTF-8 visible character counter: predicts each count and compares results.
`timescale 1ns / 100ps

module u8vc_count_checker
#(
    parameter int unsigned COUNT_WIDTH = u8vc_pkg::COUNT_WIDTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_buffer
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [31:0] visible_count
    output int          fail_count,
    output int          counts_due
);
    import u8vc_pkg::*;

    localparam logic [63:0] TALLY_CEILING = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COUNT_WIDTH);

    // Decoder copy: continuation bytes left, gathered bits, form length, pairing flag
    logic [1:0]          cont_left;
    logic [CP_WIDTH-1:0] cp_acc;
    logic [1:0]          seq_kind;
    logic                ri_open;
    logic [63:0]         visible_tally;

    // Counts owed by the block, oldest first
    logic [31:0]         due_counts[$];
    logic [31:0]         want_count;

    // Marks, selectors and joiners that take no column
    function automatic logic is_zero_width(input logic [CP_WIDTH-1:0] cp);
        return (cp >= 21'h000300 && cp <= 21'h00036F)
            || (cp >= 21'h001AB0 && cp <= 21'h001AFF)
            || (cp >= 21'h001DC0 && cp <= 21'h001DFF)
            || (cp >= 21'h0020D0 && cp <= 21'h0020FF)
            || (cp >= 21'h00FE20 && cp <= 21'h00FE2F)
            || (cp >= 21'h00FE00 && cp <= 21'h00FE0F)
            || (cp >= 21'h0E0100 && cp <= 21'h0E01EF)
            || cp == 21'h00200D
            || cp == 21'h00200C;
    endfunction

    task automatic tally_code_point(input logic [CP_WIDTH-1:0] cp);
        if (is_zero_width(cp))
            return;
        // Count the first indicator of a pair, swallow the second
        if (cp >= REGIONAL_LO && cp <= REGIONAL_HI)
        begin
            if (ri_open)
            begin
                ri_open = 1'b0;
                return;
            end
            ri_open = 1'b1;
        end
        else
        begin
            ri_open = 1'b0;
        end
        if (visible_tally < TALLY_CEILING)
            visible_tally = visible_tally + 64'd1;
    endtask

    task automatic close_sequence();
        logic [CP_WIDTH-1:0] floor_cp;
        case (seq_kind)
            SEQ_TWO:   floor_cp = MIN_CP_TWO;
            SEQ_THREE: floor_cp = MIN_CP_THREE;
            default:   floor_cp = MIN_CP_FOUR;
        endcase
        // Drop overlong forms, surrogates and values past the last plane
        if (cp_acc >= floor_cp && cp_acc <= CP_MAX
            && !(cp_acc >= SURROGATE_LO && cp_acc <= SURROGATE_HI))
            tally_code_point(cp_acc);
        cp_acc   = '0;
        seq_kind = SEQ_NONE;
    endtask

    task automatic decode_text_byte(input logic [7:0] b);
        if (cont_left != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                cp_acc    = {cp_acc[CP_WIDTH-7:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                    close_sequence();
                return;
            end
            // Broken sequence: drop it and take this byte as a fresh lead
            cont_left = 2'd0;
            cp_acc    = '0;
            seq_kind  = SEQ_NONE;
        end
        if (!b[7])
        begin
            tally_code_point({14'd0, b[6:0]});
        end
        else if (b[7:5] == 3'b110)
        begin
            cont_left = 2'd1;
            seq_kind  = SEQ_TWO;
            cp_acc    = {16'd0, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            cont_left = 2'd2;
            seq_kind  = SEQ_THREE;
            cp_acc    = {17'd0, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            cont_left = 2'd3;
            seq_kind  = SEQ_FOUR;
            cp_acc    = {18'd0, b[2:0]};
        end
        // Stray continuation bytes and 0xF8..0xFF fall through unused
    endtask

    // Predict on each accepted request, compare each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cont_left     = 2'd0;
            cp_acc        = '0;
            seq_kind      = SEQ_NONE;
            ri_open       = 1'b0;
            visible_tally = '0;
            due_counts.delete();
            fail_count    = 0;
            counts_due    <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_text_byte(s_axis_tdata);
                if (s_axis_tlast)
                begin
                    due_counts.push_back((visible_tally > 64'hFFFF_FFFF) ?
                                         32'hFFFF_FFFF : visible_tally[31:0]);
                    cont_left     = 2'd0;
                    cp_acc        = '0;
                    seq_kind      = SEQ_NONE;
                    ri_open       = 1'b0;
                    visible_tally = '0;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_counts.size() == 0)
                begin
                    $error("visible_count: expected none, got %0d", m_axis_tdata);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want_count = due_counts.pop_front();
                    if (m_axis_tdata !== want_count)
                    begin
                        $error("visible_count: expected %0d, got %0d",
                               want_count, m_axis_tdata);
                        fail_count = fail_count + 1;
                    end
                end
            end
            counts_due <= due_counts.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the UTF-8 visible character counter: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb;

    localparam int TOTAL_BYTES = 1900;
    localparam int STALL_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] text_byte
    logic        s_axis_tlast = 1'b0;   // end_of_buffer
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [31:0] visible_count

    int          fail_count;
    int          counts_due;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          bytes_sent = 0;
    int          stall_cycles = 0;
    logic [7:0]  text_q[$];

    utf8_visible_char_counter_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    u8vc_count_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .counts_due    (counts_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Abort when no request or result moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic int utf8_len(input logic [20:0] cp);
        if (cp < 21'h80)
            return 1;
        if (cp < 21'h800)
            return 2;
        if (cp < 21'h10000)
            return 3;
        return 4;
    endfunction

    // Code point for an n-byte form, never overlong; the three-byte range also takes in surrogates
    function automatic logic [20:0] rand_cp(input int n);
        case (n)
            2:       return 21'($urandom_range(32'h7FF, 32'h80));
            3:       return 21'($urandom_range(32'hFFFF, 32'h800));
            default: return 21'($urandom_range(32'h10FFFF, 32'h10000));
        endcase
    endfunction

    // Encode cp in an n-byte form, keep only the first 'keep' bytes
    task automatic push_cp(input logic [20:0] cp, input int n, input int keep);
        logic [7:0] enc[4];
        case (n)
            1: enc[0] = {1'b0, cp[6:0]};
            2:
            begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++)
            text_q.push_back(enc[i]);
    endtask

    task automatic add_token();
        int          pick;
        int          n;
        logic [20:0] cp;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            push_cp(21'($urandom_range(127)), 1, 1);
        end
        else if (pick < 62)
        begin
            n = (pick < 42) ? 2 : (pick < 54) ? 3 : 4;
            push_cp(rand_cp(n), n, n);
        end
        else if (pick < 72)
        begin
            // Non-spacing marks, selectors and joiners
            case ($urandom_range(8))
                0:       cp = 21'($urandom_range(32'h36F, 32'h300));
                1:       cp = 21'($urandom_range(32'h1AFF, 32'h1AB0));
                2:       cp = 21'($urandom_range(32'h1DFF, 32'h1DC0));
                3:       cp = 21'($urandom_range(32'h20FF, 32'h20D0));
                4:       cp = 21'($urandom_range(32'hFE2F, 32'hFE20));
                5:       cp = 21'($urandom_range(32'hFE0F, 32'hFE00));
                6:       cp = 21'($urandom_range(32'hE01EF, 32'hE0100));
                7:       cp = 21'h200D;
                default: cp = 21'h200C;
            endcase
            n = utf8_len(cp);
            push_cp(cp, n, n);
        end
        else if (pick < 82)
        begin
            repeat ($urandom_range(3, 1))
                push_cp(21'($urandom_range(32'h1F1FF, 32'h1F1E6)), 4, 4);
        end
        else if (pick < 85)
        begin
            // Overlong form
            n = $urandom_range(4, 2);
            cp = 21'($urandom_range((n == 2) ? 127 : (n == 3) ? 32'h7FF : 32'hFFFF));
            push_cp(cp, n, n);
        end
        else if (pick < 87)
        begin
            push_cp(21'($urandom_range(32'hDFFF, 32'hD800)), 3, 3);
        end
        else if (pick < 89)
        begin
            push_cp(21'($urandom_range(32'h1FFFFF, 32'h110000)), 4, 4);
        end
        else if (pick < 94)
        begin
            text_q.push_back(8'($urandom_range(255)));
        end
        else
        begin
            // Truncated sequence, broken by whatever follows
            n = $urandom_range(4, 2);
            push_cp(rand_cp(n), n, $urandom_range(n - 1, 1));
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Send the queued bytes as one buffer, tlast on the final request
    task automatic send_buffer();
        if (text_q.size() == 0)
            text_q.push_back(8'($urandom_range(255)));
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
        bytes_sent += text_q.size();
        text_q.delete();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 10;
        rx_idle_pct = 87;

        // Single-byte buffer holding NUL
        text_q = '{8'h00};
        send_buffer();
        // Edges of the one- and two-byte forms, an overlong form, bad leads, a break, a mark, a flag pair,
        // a surrogate, and a sequence cut short by the end of the buffer
        text_q = '{8'h7F, 8'hC2, 8'h80, 8'hC0, 8'h80, 8'h80, 8'hF8, 8'hFF,
                   8'hC3, 8'h41, 8'hCC, 8'h81, 8'hF0, 8'h9F, 8'h87, 8'hA6,
                   8'hF0, 8'h9F, 8'h87, 8'hA7, 8'hED, 8'hA0, 8'h80, 8'hE2, 8'h82};
        send_buffer();

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 87 : 0;
            rx_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 10 : 0;
            while (bytes_sent < (phase + 1) * TOTAL_BYTES / 3)
            begin
                repeat ($urandom_range(10, 1))
                    add_token();
                send_buffer();
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain the outstanding counts, then watch for strays
        @(posedge clk);
        while (counts_due != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && counts_due == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== utf8_visible_char_counter_core.f =====
rtl/u8vc_pkg.sv
rtl/u8vc_decode.sv
rtl/utf8_visible_char_counter_core.sv
rtl/u8vc_checker.sv
tb/u8vc_count_checker.sv
tb/tb.sv
